// ===== src/ffls_pkg.sv =====
// shared types, constants and helpers for the f-string field lint scanner
// depends on nothing; every other file of the block imports it
package ffls_pkg;

    localparam int LINE_BITS_DEF  = 32;
    localparam int DEPTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic KIND_PLAIN_FIELD = 1'b0;
    localparam logic KIND_FSTR_EMPTY  = 1'b1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_of_file;
    } in_item_t;

    typedef struct packed {
        logic        warning_kind;
        logic [31:0] line_number;
        logic [31:0] issue_count;
    } out_item_t;

    // warning found by the lexer, waiting for its issue number
    typedef struct packed {
        logic        restart;
        logic        warning_kind;
        logic [31:0] line_number;
    } warn_event_t;

    function automatic logic is_separator(input logic [7:0] c);
        logic r;
        begin
            unique case (c)
                8'h09, 8'h0A, 8'h0D, 8'h20, 8'h25, 8'h26, 8'h28, 8'h29,
                8'h2A, 8'h2B, 8'h2D, 8'h2F, 8'h3A, 8'h3C, 8'h3D, 8'h3E,
                8'h5B, 8'h5D, 8'h5E, 8'h7E: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/fstring_field_lint_scanner.sv =====
// top level of the f-string field lint scanner: front lexer, event fifo, back end
// depends on ffls_pkg, ffls_front, ffls_queue, ffls_back
//
// Takes one Python source byte per clock (push while full is low) and reports a
// result only when a string closes and is suspicious: a plain string holding
// unnested, closed {fields}, or an f-string with none, nested ones or an open
// brace. Each result carries the 1-based line number and the running warning
// count for the file, both saturating at 32 bits; first_of_file on a byte
// restarts the lexer, the line count and the warning numbering before that
// byte. The lexer handles one byte per cycle while full is low; full rises only
// when the four-entry warning fifo and the result register are all occupied
// because the result side is not popping. A result passes from the lexer
// through the warning fifo into the result register once that register is free.
module fstring_field_lint_scanner
    import ffls_pkg::*;
#(
    parameter int LINE_BITS  = LINE_BITS_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic        take;
    logic        ev_valid;
    warn_event_t ev_in, ev_out;
    logic        q_full, q_empty, q_rd;

    // the front only advances when its possible warning has room
    assign full = q_full;
    assign take = push && !q_full;

    ffls_front #(
        .LINE_BITS  (LINE_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .ev_valid (ev_valid),
        .ev       (ev_in)
    );

    ffls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_valid),
        .wr_data (ev_in),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .q_empty (q_empty),
        .rd_data (ev_out)
    );

    ffls_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .ev      (ev_out),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== src/ffls_front.sv =====
// lexer front end: takes one source byte per request and finds string warnings
// depends on ffls_pkg; feeds ffls_queue
module ffls_front
    import ffls_pkg::*;
#(
    parameter int LINE_BITS  = LINE_BITS_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  in_item_t    item,
    output logic        ev_valid,
    output warn_event_t ev
);

    typedef enum logic [11:0] {
        S_IDLE        = 12'b0000_0000_0001,
        S_PREFIX      = 12'b0000_0000_0010,
        S_STR_SQ      = 12'b0000_0000_0100,
        S_STR_DQ      = 12'b0000_0000_1000,
        S_FSTR_SQ     = 12'b0000_0001_0000,
        S_FSTR_DQ     = 12'b0000_0010_0000,
        S_ESC_STR_SQ  = 12'b0000_0100_0000,
        S_ESC_STR_DQ  = 12'b0000_1000_0000,
        S_ESC_FSTR_SQ = 12'b0001_0000_0000,
        S_ESC_FSTR_DQ = 12'b0010_0000_0000,
        S_TOKEN       = 12'b0100_0000_0000,
        S_COMMENT     = 12'b1000_0000_0000
    } scan_state_t;

    scan_state_t             state_reg, state_next, state_base;
    logic [DEPTH_BITS-1:0]   depth_reg, depth_next, depth_base, depth_inc;
    logic [DEPTH_BITS-1:0]   peak_reg, peak_next, peak_base;
    logic [LINE_BITS-1:0]    line_reg, line_next, line_base;
    logic                    restart_reg, restart_next;
    logic [31:0]             line_sat;
    logic [7:0]              c;
    logic                    in_string, dq, fstr, one_field, warn;

    assign c = item.byte_value;

    always_comb
    begin
        state_base = item.first_of_file ? S_IDLE : state_reg;
        depth_base = item.first_of_file ? '0 : depth_reg;
        peak_base  = item.first_of_file ? '0 : peak_reg;
        line_base  = item.first_of_file ? LINE_BITS'(1) : line_reg;
    end

    // newline is counted before the byte is scanned
    assign line_next = (c == CH_NEWLINE && line_base != '1) ? line_base + 1'b1 : line_base;

    generate
        if (LINE_BITS > 32)
        begin : g_line_wide
            assign line_sat = (|line_next[LINE_BITS-1:32]) ? 32'hFFFF_FFFF : line_next[31:0];
        end
        else
        begin : g_line_narrow
            assign line_sat = 32'(line_next);
        end
    endgenerate

    assign in_string = (state_base == S_STR_SQ) || (state_base == S_STR_DQ)
                    || (state_base == S_FSTR_SQ) || (state_base == S_FSTR_DQ);
    assign dq        = (state_base == S_STR_DQ) || (state_base == S_FSTR_DQ);
    assign fstr      = (state_base == S_FSTR_SQ) || (state_base == S_FSTR_DQ);
    assign one_field = (depth_base == '0) && (peak_base == DEPTH_BITS'(1));
    assign depth_inc = (depth_base != '1) ? depth_base + 1'b1 : depth_base;

    always_comb
    begin
        state_next = state_base;
        depth_next = depth_base;
        peak_next  = peak_base;
        warn       = 1'b0;
        unique case (state_base)
            S_PREFIX:
            begin
                if (c == CH_SQUOTE)
                    state_next = S_FSTR_SQ;
                else if (c == CH_DQUOTE)
                    state_next = S_FSTR_DQ;
                else
                    state_next = S_IDLE;
            end
            S_STR_SQ, S_STR_DQ, S_FSTR_SQ, S_FSTR_DQ:
            begin
                if (c == CH_LBRACE)
                begin
                    depth_next = depth_inc;
                    if (depth_inc > peak_base)
                        peak_next = depth_inc;
                end
                else if (c == CH_RBRACE)
                begin
                    if (depth_base != '0)
                        depth_next = depth_base - 1'b1;
                end
                else if (c == CH_BSLASH)
                begin
                    unique case (state_base)
                        S_STR_SQ:  state_next = S_ESC_STR_SQ;
                        S_STR_DQ:  state_next = S_ESC_STR_DQ;
                        S_FSTR_SQ: state_next = S_ESC_FSTR_SQ;
                        default:   state_next = S_ESC_FSTR_DQ;
                    endcase
                end
                else if ((c == CH_SQUOTE && !dq) || (c == CH_DQUOTE && dq))
                begin
                    warn       = fstr != one_field;
                    state_next = S_IDLE;
                    depth_next = '0;
                    peak_next  = '0;
                end
            end
            S_ESC_STR_SQ:  state_next = S_STR_SQ;
            S_ESC_STR_DQ:  state_next = S_STR_DQ;
            S_ESC_FSTR_SQ: state_next = S_FSTR_SQ;
            S_ESC_FSTR_DQ: state_next = S_FSTR_DQ;
            S_TOKEN:
            begin
                if (c == CH_SQUOTE)
                    state_next = S_STR_SQ;
                else if (c == CH_DQUOTE)
                    state_next = S_STR_DQ;
                else if (c == CH_HASH)
                    state_next = S_COMMENT;
                else if (is_separator(c))
                    state_next = S_IDLE;
            end
            S_COMMENT:
            begin
                if (c == CH_NEWLINE)
                    state_next = S_IDLE;
            end
            default:
            begin
                if (c == CH_UPPER_F || c == CH_LOWER_F)
                    state_next = S_PREFIX;
                else if (c == CH_SQUOTE)
                    state_next = S_STR_SQ;
                else if (c == CH_DQUOTE)
                    state_next = S_STR_DQ;
                else if (c == CH_HASH)
                    state_next = S_COMMENT;
                else if (is_separator(c))
                    state_next = S_IDLE;
                else
                    state_next = S_TOKEN;
            end
        endcase
    end

    // a file restart travels with the next warning so the back end can renumber
    assign restart_next = warn ? 1'b0 : (item.first_of_file | restart_reg);

    assign ev_valid        = take && warn;
    assign ev.restart      = item.first_of_file | restart_reg;
    assign ev.warning_kind = fstr ? KIND_FSTR_EMPTY : KIND_PLAIN_FIELD;
    assign ev.line_number  = line_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            peak_reg    <= '0;
            line_reg    <= LINE_BITS'(1);
            restart_reg <= 1'b0;
        end
        else if (take)
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            peak_reg    <= peak_next;
            line_reg    <= line_next;
            restart_reg <= restart_next;
        end
    end

endmodule

// ===== src/ffls_queue.sv =====
// short fifo of warning events between the lexer and the numbering stage
// depends on ffls_pkg
module ffls_queue
    import ffls_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  warn_event_t wr_data,
    output logic        q_full,
    input  logic        rd_en,
    output logic        q_empty,
    output warn_event_t rd_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    warn_event_t         slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign q_full  = cnt_reg == CNT_BITS'(DEPTH);
    assign q_empty = cnt_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CNT_BITS'(do_wr) - CNT_BITS'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== src/ffls_back.sv =====
// back end: numbers each warning and holds it in the result register
// depends on ffls_pkg; drains ffls_queue
module ffls_back
    import ffls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  warn_event_t ev,
    output logic        q_rd,
    output logic        empty,
    input  logic        pop,
    output out_item_t   result
);

    logic        valid_reg, valid_next;
    out_item_t   out_reg, out_next;
    logic [31:0] count_reg, count_next;
    logic        load;

    // refill when the register is free or being taken this cycle
    assign load = !q_empty && (!valid_reg || pop);
    assign q_rd = load;

    always_comb
    begin
        count_next = count_reg;
        if (ev.restart)
            count_next = 32'd1;
        else if (count_reg != 32'hFFFF_FFFF)
            count_next = count_reg + 32'd1;
    end

    always_comb
    begin
        out_next.warning_kind = ev.warning_kind;
        out_next.line_number  = ev.line_number;
        out_next.issue_count  = count_next;
        valid_next = load ? 1'b1 : (valid_reg && !pop);
    end

    assign empty  = !valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

endmodule

// ===== src/ffls_checker.sv =====
// port-level checks for the f-string field lint scanner, bound to the top level
// depends on ffls_pkg and fstring_field_lint_scanner
module ffls_checker
    import ffls_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    // a waiting result holds until it is taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed before pop");

    // every reported warning is numbered from one
    a_issue_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.issue_count != 32'd0))
        else $error("issue count of zero");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.line_number != 32'd0))
        else $error("line number of zero");

    // a result left waiting keeps its number
    a_issue_climbs: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !push && !$past(push) && !$past(push, 2)
            && $past(!empty) && !$past(pop) && !$past(pop, 2)) |->
        (result.issue_count == $past(result.issue_count)))
        else $error("result changed without a new warning");

endmodule

bind fstring_field_lint_scanner ffls_checker u_ffls_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
